// ===== hw/rtl/timer_bank_one_shot_reload_core_macros.svh =====
// ----------------------------------------------------------------------------
// Timer bank assertion macros
// Shared property wrappers for the timer bank checker, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIMER_BANK_ONE_SHOT_RELOAD_CORE_MACROS_SVH
`define TIMER_BANK_ONE_SHOT_RELOAD_CORE_MACROS_SVH

// Property must hold at every clock edge outside reset
`define TBOR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset
`define TBOR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/tbor_pkg.sv =====
// ----------------------------------------------------------------------------
// tbor_pkg
// Shared constants, codes and inter-module structs of the timer bank.
// ----------------------------------------------------------------------------
package tbor_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int DATA_W     = 32;
  localparam int ID_W       = 4;
  localparam int OP_W       = 3;
  localparam int ST_W       = 3;
  localparam int ADDR_W     = 3;

  localparam logic [DATA_W-1:0] COUNT_IDLE  = '1;
  localparam logic [DATA_W-1:0] DIV_RESET   = 32'd1;

  // Input operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_RESTART = 3'd3,
    OP_SCAN    = 3'd4,
    OP_QUERY   = 3'd5
  } op_t;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_DONE        = 3'd0,
    ST_STARTED     = 3'd1,
    ST_IN_USE      = 3'd2,
    ST_EXPIRED     = 3'd3,
    ST_NOT_EXPIRED = 3'd4,
    ST_EVENT       = 3'd5
  } status_t;

  // Write command into the timer bank
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic              wr_count;
    logic [DATA_W-1:0] count;
    logic              wr_limit;
    logic [DATA_W-1:0] limit;
    logic              wr_exp;
    logic              exp;
    logic              wr_mode;
    logic              mode;
    logic              wr_hnd;
    logic              hnd;
  } bank_wr_t;

  // One timer entry as read from the bank
  typedef struct packed {
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] limit;
    logic              expired;
    logic              reload;
    logic              handler;
  } bank_rd_t;

  // Shared increment/compare unit result
  typedef struct packed {
    logic [DATA_W-1:0] inc;
    logic              inc_eq;
    logic              le;
  } alu_res_t;

endpackage

// ===== hw/rtl/timer_bank_one_shot_reload_core.sv =====
// ----------------------------------------------------------------------------
// timer_bank_one_shot_reload_core
// Bank of one-shot / auto-reload timers behind a base-tick prescaler.
// ----------------------------------------------------------------------------
// Timing: one word is taken at a time; in_ready is high only while the
// sequencer is idle. Start, stop, restart, query and a base tick that does not
// reach the divider pass an accept step and an execute step; execute waits
// until the output register is free. A base tick that rolls the prescaler and
// an event scan each walk the bank one timer per cycle through the one-entry
// bank read port, the tick walk also through the single shared increment/compare
// unit; a scan holds on a timer whose report waits on out_ready. Results leave
// through a one-word output register; each scan yields one expiry word per
// flagged timer with a handler, then a done word with out_last set.
module timer_bank_one_shot_reload_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // input words
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tbor_pkg::OP_W-1:0]   in_op,
  input  logic [tbor_pkg::ID_W-1:0]   in_timer_id,
  input  logic                        in_auto_reload,
  input  logic                        in_has_handler,
  input  logic [tbor_pkg::DATA_W-1:0] in_timeout,
  // result words
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tbor_pkg::ST_W-1:0]   out_status,
  output logic [tbor_pkg::ID_W-1:0]   out_event_timer,
  output logic                        out_last,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tbor_pkg::ADDR_W-1:0] paddr,
  input  logic [tbor_pkg::DATA_W-1:0] pwdata,
  output logic [tbor_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import tbor_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TICK,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic              reload_r, reload_nxt;
  logic              handler_r, handler_nxt;
  logic [DATA_W-1:0] timeout_r, timeout_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [DATA_W-1:0] prescale_r, prescale_nxt;

  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [ID_W-1:0]   out_id_r;
  logic              out_last_r;

  logic              emit;
  status_t           emit_status;
  logic [ID_W-1:0]   emit_id;
  logic              emit_last;

  logic              out_free;
  logic              id_ok;
  logic              idx_end;
  logic              need_emit;
  logic [IDX_W-1:0]  rd_idx;
  logic [DATA_W-1:0] alu_a;
  logic [DATA_W-1:0] alu_b;
  logic [DATA_W-1:0] divider;
  bank_wr_t          wr;
  bank_rd_t          rd;
  alu_res_t          alu;

  tbor_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .divider (divider)
  );

  tbor_bank u_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (rd_idx),
    .wr     (wr),
    .rd     (rd)
  );

  tbor_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign id_ok     = int'(id_r) < NUM_TIMERS;
  assign idx_end   = (idx_r == IDX_W'(NUM_TIMERS - 1));
  assign need_emit = rd.expired && rd.handler;
  assign in_ready  = (state_r == S_IDLE);

  // Bank address and shared unit operands
  assign rd_idx = (state_r == S_EXEC) ? IDX_W'(id_r) : idx_r;
  assign alu_a  = (state_r == S_EXEC && op_r == OP_TICK) ? prescale_r : rd.count;
  assign alu_b  = (state_r == S_EXEC && op_r == OP_TICK) ? divider    : rd.limit;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    id_nxt       = id_r;
    reload_nxt   = reload_r;
    handler_nxt  = handler_r;
    timeout_nxt  = timeout_r;
    idx_nxt      = idx_r;
    prescale_nxt = prescale_r;
    wr           = '0;
    emit         = 1'b0;
    emit_status  = ST_DONE;
    emit_id      = '0;
    emit_last    = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_op;
          id_nxt      = in_timer_id;
          reload_nxt  = in_auto_reload;
          handler_nxt = in_has_handler;
          timeout_nxt = in_timeout;
          state_nxt   = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          wr.idx    = IDX_W'(id_r);
          emit      = 1'b1;
          emit_id   = id_r;
          state_nxt = S_IDLE;
          case (op_r)
            OP_TICK: begin
              emit_id = '0;
              if (alu.inc_eq) begin
                // prescaler rolls over: walk the bank
                prescale_nxt = '0;
                idx_nxt      = '0;
                emit         = 1'b0;
                state_nxt    = S_TICK;
              end else begin
                prescale_nxt = alu.inc;
              end
            end
            OP_START: begin
              if (!id_ok || alu.le) begin
                emit_status = ST_IN_USE;
              end else begin
                emit_status = ST_STARTED;
                wr.en       = 1'b1;
                wr.wr_count = 1'b1;
                wr.count    = '0;
                wr.wr_limit = 1'b1;
                wr.limit    = timeout_r;
                wr.wr_exp   = 1'b1;
                wr.exp      = 1'b0;
                wr.wr_mode  = 1'b1;
                wr.mode     = reload_r;
                wr.wr_hnd   = 1'b1;
                wr.hnd      = handler_r;
              end
            end
            OP_STOP: begin
              wr.en       = id_ok;
              wr.wr_count = 1'b1;
              wr.count    = COUNT_IDLE;
              wr.wr_limit = 1'b1;
              wr.limit    = '0;
              wr.wr_exp   = 1'b1;
              wr.exp      = 1'b0;
              wr.wr_hnd   = 1'b1;
              wr.hnd      = 1'b0;
            end
            OP_RESTART: begin
              wr.en       = id_ok;
              wr.wr_count = 1'b1;
              wr.count    = '0;
              wr.wr_exp   = 1'b1;
              wr.exp      = 1'b0;
            end
            OP_SCAN: begin
              idx_nxt   = '0;
              emit      = 1'b0;
              state_nxt = S_SCAN;
            end
            OP_QUERY: begin
              emit_status = (!id_ok || !alu.le) ? ST_EXPIRED : ST_NOT_EXPIRED;
            end
            default: begin
              emit_status = ST_DONE;
            end
          endcase
        end
      end

      // one timer per cycle: count up unless already flagged
      S_TICK: begin
        wr.idx = idx_r;
        if (!rd.expired) begin
          wr.en       = 1'b1;
          wr.wr_count = 1'b1;
          wr.count    = alu.inc;
          wr.wr_exp   = 1'b1;
          wr.exp      = alu.inc_eq;
        end
        if (idx_end) begin
          state_nxt = S_FINISH;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      // one timer per cycle unless a pending report waits on the output: report, then clear or reload
      S_SCAN: begin
        wr.idx = idx_r;
        if (!need_emit || out_free) begin
          if (need_emit) begin
            emit        = 1'b1;
            emit_status = ST_EVENT;
            emit_id     = ID_W'(idx_r);
            emit_last   = 1'b0;
          end
          if (rd.expired) begin
            wr.en       = 1'b1;
            wr.wr_exp   = 1'b1;
            wr.exp      = 1'b0;
            wr.wr_count = rd.reload;
            wr.count    = '0;
          end
          if (idx_end) begin
            state_nxt = S_FINISH;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, control and output word registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      prescale_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      prescale_r <= prescale_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    op_r      <= op_nxt;
    id_r      <= id_nxt;
    reload_r  <= reload_nxt;
    handler_r <= handler_nxt;
    timeout_r <= timeout_nxt;
    if (emit) begin
      out_status_r <= emit_status;
      out_id_r     <= emit_id;
      out_last_r   <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_event_timer = out_id_r;
  assign out_last        = out_last_r;

endmodule

// ===== hw/rtl/tbor_cfg.sv =====
// ----------------------------------------------------------------------------
// tbor_cfg
// APB register file: holds the tick divider.
// ----------------------------------------------------------------------------
module tbor_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tbor_pkg::ADDR_W-1:0] paddr,
  input  logic [tbor_pkg::DATA_W-1:0] pwdata,
  output logic [tbor_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output logic [tbor_pkg::DATA_W-1:0] divider
);
  import tbor_pkg::*;

  // Register index is the word address bit
  localparam logic REG_DIVIDER = 1'b0;

  logic [DATA_W-1:0] divider_r;
  logic              wr_en;

  assign wr_en  = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_DIVIDER);
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_DIVIDER) ? divider_r : '0;
  assign divider = divider_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divider_r <= DIV_RESET;
    end else if (wr_en) begin
      divider_r <= pwdata;
    end
  end

endmodule

// ===== hw/rtl/tbor_alu.sv =====
// ----------------------------------------------------------------------------
// tbor_alu
// Shared 32-bit increment and compare unit used by the execute and tick-walk steps.
// ----------------------------------------------------------------------------
module tbor_alu (
  input  logic [tbor_pkg::DATA_W-1:0] a,
  input  logic [tbor_pkg::DATA_W-1:0] b,
  output tbor_pkg::alu_res_t          res
);
  import tbor_pkg::*;

  // a+1 wraps at 32 bits
  assign res.inc    = a + DATA_W'(1);
  assign res.inc_eq = (res.inc == b);
  assign res.le     = (a <= b);

endmodule

// ===== hw/rtl/tbor_bank.sv =====
// ----------------------------------------------------------------------------
// tbor_bank
// Timer state: count, limit and per-timer flags, one read and one write
// port.
// ----------------------------------------------------------------------------
module tbor_bank (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [tbor_pkg::IDX_W-1:0] rd_idx,
  input  tbor_pkg::bank_wr_t         wr,
  output tbor_pkg::bank_rd_t         rd
);
  import tbor_pkg::*;

  logic [DATA_W-1:0]     count_r [NUM_TIMERS];
  logic [DATA_W-1:0]     limit_r [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] expired_r;
  logic [NUM_TIMERS-1:0] reload_r;
  logic [NUM_TIMERS-1:0] handler_r;

  // Read port
  assign rd.count   = count_r[rd_idx];
  assign rd.limit   = limit_r[rd_idx];
  assign rd.expired = expired_r[rd_idx];
  assign rd.reload  = reload_r[rd_idx];
  assign rd.handler = handler_r[rd_idx];

  // Write port, reset to the stopped state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        count_r[i] <= COUNT_IDLE;
        limit_r[i] <= '0;
      end
      expired_r <= '0;
      reload_r  <= '0;
      handler_r <= '0;
    end else if (wr.en) begin
      if (wr.wr_count) count_r[wr.idx]   <= wr.count;
      if (wr.wr_limit) limit_r[wr.idx]   <= wr.limit;
      if (wr.wr_exp)   expired_r[wr.idx] <= wr.exp;
      if (wr.wr_mode)  reload_r[wr.idx]  <= wr.mode;
      if (wr.wr_hnd)   handler_r[wr.idx] <= wr.hnd;
    end
  end

endmodule

// ===== hw/rtl/tbor_checker.sv =====
// ----------------------------------------------------------------------------
// tbor_checker
// Port-level checks of the timer bank, bound to the top level.
// ----------------------------------------------------------------------------
`include "timer_bank_one_shot_reload_core_macros.svh"

module tbor_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [tbor_pkg::ST_W-1:0] out_status,
  input logic [tbor_pkg::ID_W-1:0] out_event_timer,
  input logic                      out_last
);
  import tbor_pkg::*;

  // stalled result word holds
  `TBOR_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_event_timer) && $stable(out_last)), "result word changed while stalled")

  // one word in flight: ready drops after an accept
  `TBOR_ASSERT(a_one_item, (in_valid && in_ready) |=> !in_ready, "input accepted while busy")

  // only expiry events are non-final
  `TBOR_ASSERT_NEVER(a_nonlast_event, out_valid && !out_last && (out_status != ST_EVENT), "non-final word is not an expiry event")

  // an expiry event is never the final word
  `TBOR_ASSERT_NEVER(a_event_not_last, out_valid && out_last && (out_status == ST_EVENT), "expiry event marked last")

endmodule

bind timer_bank_one_shot_reload_core tbor_checker u_tbor_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_event_timer (out_event_timer),
  .out_last        (out_last)
);

// ===== bench/timer_bank_one_shot_reload_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank self-checking testbench
// Runs a short directed script of commands (reset state, timeout extremes,
// refused starts, unknown opcodes), then random command streams under several
// tick dividers. Each accepted command word is run through a behavioral copy
// of the bank; every reply word is checked field by field, in order.
// ----------------------------------------------------------------------------
module timer_bank_one_shot_reload_core_test;
  import tbor_pkg::*;

  localparam int          HALF_PERIOD      = 5;
  localparam int          RESET_CYCLES     = 7;
  localparam int          SETTLE_CYCLES    = 24;   // covers one full bank walk, with margin
  localparam int          LIMIT_CYCLES     = 400000;
  localparam int          MAX_REPORTS      = 10;
  localparam int          NUM_PHASES       = 5;
  localparam logic [ADDR_W-1:0] REG_TICK_DIVIDER = 3'd0;
  // opcodes outside the defined set
  localparam logic [OP_W-1:0]   OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0]   OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic              reload;
    logic              handler;
    logic [DATA_W-1:0] timeout;
  } cmd_word_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] timer;
    logic            last;
  } reply_word_t;

  // script row: command plus a hand-written reply where it is obvious
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic              reload;
    logic              handler;
    logic [DATA_W-1:0] timeout;
    logic              fixed;
    logic [ST_W-1:0]   st;
    logic [ID_W-1:0]   tmr;
  } script_row_t;

  // DUT ports
  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_op           = '0;
  logic [ID_W-1:0]   in_timer_id     = '0;
  logic              in_auto_reload  = 1'b0;
  logic              in_has_handler  = 1'b0;
  logic [DATA_W-1:0] in_timeout      = '0;
  logic              out_valid;
  logic              out_ready       = 1'b0;
  logic [ST_W-1:0]   out_status;
  logic [ID_W-1:0]   out_event_timer;
  logic              out_last;
  logic              psel            = 1'b0;
  logic              penable         = 1'b0;
  logic              pwrite          = 1'b0;
  logic [ADDR_W-1:0] paddr           = '0;
  logic [DATA_W-1:0] pwdata          = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // behavioral copy of the bank
  logic [DATA_W-1:0]     divider  = DIV_RESET;
  logic [DATA_W-1:0]     prescale = '0;
  logic [DATA_W-1:0]     t_count [NUM_TIMERS];
  logic [DATA_W-1:0]     t_limit [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] t_expired = '0;
  logic [NUM_TIMERS-1:0] t_reload  = '0;
  logic [NUM_TIMERS-1:0] t_handler = '0;

  reply_word_t expected_replies [$];
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_left   = 0;
  bit          sender_burst = 1'b0;
  bit          receiver_burst = 1'b0;

  logic [DATA_W-1:0] divider_plan [NUM_PHASES] = '{32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF, 32'd0};

  script_row_t script [22] = '{
    '{OP_QUERY,      4'd0,  1'b0, 1'b0, 32'h0000_0000, 1'b1, ST_EXPIRED,     4'd0},
    '{OP_START,      4'd0,  1'b0, 1'b1, 32'h0000_0002, 1'b1, ST_STARTED,     4'd0},
    '{OP_START,      4'd0,  1'b1, 1'b0, 32'h0000_0007, 1'b1, ST_IN_USE,      4'd0},
    '{OP_START,      4'd15, 1'b1, 1'b1, 32'h0000_0001, 1'b1, ST_STARTED,     4'd15},
    '{OP_QUERY,      4'd15, 1'b0, 1'b0, 32'h0000_0000, 1'b1, ST_NOT_EXPIRED, 4'd15},
    '{OP_TICK,       4'd15, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_DONE,        4'd0},
    '{OP_TICK,       4'd0,  1'b0, 1'b0, 32'h0000_0000, 1'b1, ST_DONE,        4'd0},
    '{OP_SCAN,       4'd0,  1'b0, 1'b0, 32'h0000_0000, 1'b0, ST_DONE,        4'd0},
    '{OP_QUERY,      4'd0,  1'b0, 1'b0, 32'h0000_0000, 1'b0, ST_DONE,        4'd0},
    '{OP_QUERY,      4'd15, 1'b0, 1'b0, 32'h0000_0000, 1'b0, ST_DONE,        4'd0},
    '{OP_STOP,       4'd0,  1'b0, 1'b0, 32'h0000_0000, 1'b1, ST_DONE,        4'd0},
    '{OP_RESTART,    4'd15, 1'b0, 1'b0, 32'h0000_0000, 1'b1, ST_DONE,        4'd15},
    '{OP_START,      4'd3,  1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, ST_DONE,        4'd0},
    '{OP_TICK,       4'd0,  1'b0, 1'b0, 32'h0000_0000, 1'b0, ST_DONE,        4'd0},
    '{OP_START,      4'd3,  1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, ST_DONE,        4'd0},
    '{OP_SPARE_6,    4'd9,  1'b0, 1'b0, 32'h0000_0000, 1'b1, ST_DONE,        4'd9},
    '{OP_SPARE_7,    4'd10, 1'b1, 1'b1, 32'hAAAA_AAAA, 1'b1, ST_DONE,        4'd10},
    '{OP_START,      4'd5,  1'b1, 1'b1, 32'h5555_5555, 1'b0, ST_DONE,        4'd0},
    '{OP_TICK,       4'd0,  1'b0, 1'b0, 32'h0000_0000, 1'b0, ST_DONE,        4'd0},
    '{OP_SCAN,       4'd0,  1'b0, 1'b0, 32'h0000_0000, 1'b0, ST_DONE,        4'd0},
    '{OP_QUERY,      4'd3,  1'b0, 1'b0, 32'h0000_0000, 1'b0, ST_DONE,        4'd0},
    '{OP_START,      4'd0,  1'b0, 1'b1, 32'h0000_0000, 1'b0, ST_DONE,        4'd0}
  };

  timer_bank_one_shot_reload_core dut (.*);

  always #HALF_PERIOD clk = ~clk;

  function automatic void report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  function automatic void push_reply(logic [ST_W-1:0] st, logic [ID_W-1:0] tmr, logic lst);
    expected_replies.push_back('{st, tmr, lst});
  endfunction

  // Advance the bank copy by one command word and queue its replies
  function automatic void predict_replies(cmd_word_t w);
    int i;
    case (w.op)
      OP_TICK: begin
        prescale = prescale + 32'd1;
        if (prescale == divider) begin
          prescale = '0;
          for (i = 0; i < NUM_TIMERS; i++) begin
            if (!t_expired[i]) begin
              t_count[i] = t_count[i] + 32'd1;
              if (t_count[i] == t_limit[i]) t_expired[i] = 1'b1;
            end
          end
        end
        push_reply(ST_DONE, '0, 1'b1);
      end
      OP_START: begin
        if (t_count[w.id] <= t_limit[w.id]) begin
          push_reply(ST_IN_USE, w.id, 1'b1);
        end else begin
          t_reload[w.id]  = w.reload;
          t_limit[w.id]   = w.timeout;
          t_handler[w.id] = w.handler;
          t_count[w.id]   = '0;
          t_expired[w.id] = 1'b0;
          push_reply(ST_STARTED, w.id, 1'b1);
        end
      end
      OP_STOP: begin
        t_count[w.id]   = COUNT_IDLE;
        t_limit[w.id]   = '0;
        t_expired[w.id] = 1'b0;
        t_handler[w.id] = 1'b0;
        push_reply(ST_DONE, w.id, 1'b1);
      end
      OP_RESTART: begin
        t_count[w.id]   = '0;
        t_expired[w.id] = 1'b0;
        push_reply(ST_DONE, w.id, 1'b1);
      end
      OP_SCAN: begin
        // events in index order, then done
        for (i = 0; i < NUM_TIMERS; i++) begin
          if (t_expired[i]) begin
            if (t_handler[i]) push_reply(ST_EVENT, i[ID_W-1:0], 1'b0);
            if (t_reload[i]) t_count[i] = '0;
            t_expired[i] = 1'b0;
          end
        end
        push_reply(ST_DONE, '0, 1'b1);
      end
      OP_QUERY: begin
        if (t_count[w.id] > t_limit[w.id]) push_reply(ST_EXPIRED, w.id, 1'b1);
        else push_reply(ST_NOT_EXPIRED, w.id, 1'b1);
      end
      default: push_reply(ST_DONE, w.id, 1'b1);
    endcase
  endfunction

  // Random command word, weighted toward ticks and starts with short timeouts
  function automatic cmd_word_t draw_word();
    cmd_word_t   w;
    int unsigned r;
    r = $urandom_range(0, 99);
    w.id      = ID_W'($urandom_range(0, NUM_TIMERS - 1));
    w.reload  = 1'($urandom_range(0, 1));
    w.handler = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: w.timeout = $urandom_range(0, 4);
      6:                w.timeout = $urandom;
      7:                w.timeout = '0;
      8:                w.timeout = '1;
      default:          w.timeout = $urandom_range(5, 40);
    endcase
    if (r < 40)      w.op = OP_TICK;
    else if (r < 62) w.op = OP_START;
    else if (r < 75) w.op = OP_SCAN;
    else if (r < 85) w.op = OP_QUERY;
    else if (r < 91) w.op = OP_STOP;
    else if (r < 97) w.op = OP_RESTART;
    else             w.op = (r[0]) ? OP_SPARE_7 : OP_SPARE_6;
    return w;
  endfunction

  // Present one command word and wait for it to be taken
  task automatic send_word(input cmd_word_t w, input logic fixed, input reply_word_t fixed_reply);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= w.op;
    in_timer_id    <= w.id;
    in_auto_reload <= w.reload;
    in_has_handler <= w.handler;
    in_timeout     <= w.timeout;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_replies(w);
    if (fixed) begin
      void'(expected_replies.pop_back());
      expected_replies.push_back(fixed_reply);
    end
  endtask

  // Hold off the sender until every reply is in, then let the bank settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: check each word taken, then draw the next stall
  always @(posedge clk) begin
    reply_word_t e;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected word status=%0d timer=%0d last=%0d",
                                    out_status, out_event_timer, out_last));
        end else begin
          e = expected_replies.pop_front();
          if (out_status !== e.status)
            report_mismatch($sformatf("status exp=%0d got=%0d", e.status, out_status));
          if (out_event_timer !== e.timer)
            report_mismatch($sformatf("event_timer exp=%0d got=%0d", e.timer, out_event_timer));
          if (out_last !== e.last)
            report_mismatch($sformatf("last exp=%0d got=%0d", e.last, out_last));
        end
        if ($urandom_range(0, 19) == 0) receiver_burst = !receiver_burst;
        stall_left = receiver_burst ? 0 : $urandom_range(0, 16);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timer_bank_one_shot_reload_core_test: FAIL");
      $finish;
    end
  end

  initial begin
    int          p;
    int          n;
    int          phase_len;
    cmd_word_t   w;
    logic [DATA_W-1:0] rd;

    for (p = 0; p < NUM_TIMERS; p++) begin
      t_count[p] = COUNT_IDLE;
      t_limit[p] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed script
    for (n = 0; n < $size(script); n++) begin
      w = '{script[n].op, script[n].id, script[n].reload, script[n].handler, script[n].timeout};
      sender_burst = (n >= 16);
      send_word(w, script[n].fixed, '{script[n].st, script[n].tmr, 1'b1});
    end

    // random phases, one per entry of divider_plan
    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= REG_TICK_DIVIDER;
      pwdata  <= divider_plan[p];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      divider = divider_plan[p];
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (rd !== divider)
        report_mismatch($sformatf("tick_divider readback exp=%0h got=%0h", divider, rd));

      phase_len    = (divider == 32'd0 || divider == 32'hFFFF_FFFF) ? 10 : 20;
      sender_burst = ($urandom_range(0, 3) == 0);
      for (n = 0; n < phase_len; n++) begin
        if ($urandom_range(0, 24) == 0) drain();
        send_word(draw_word(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("timer_bank_one_shot_reload_core_test: PASS");
    end else begin
      $display("timer_bank_one_shot_reload_core_test: FAIL");
    end
    $finish;
  end

endmodule
